>>> sv/texture_coord_transform_wrap_core_macros.svh
// Assertion macros shared by the texture coordinate transform modules.
`ifndef TEXTURE_COORD_TRANSFORM_WRAP_CORE_MACROS_SVH
`define TEXTURE_COORD_TRANSFORM_WRAP_CORE_MACROS_SVH

`ifndef SYNTH
`define TCT_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define TCT_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define TCT_ASSERT_NOW(lbl, ante, cons)
`define TCT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/tct_pkg.sv
// Types and codes shared by the texture coordinate transform modules.
package tct_pkg;

	typedef enum logic [2:0] {
		WRAP_REPEAT = 3'd0,
		WRAP_MIRROR = 3'd1,
		WRAP_CLAMP  = 3'd2,
		WRAP_PLANAR = 3'd3,
		WRAP_CUBIC  = 3'd4
	} wrap_mode_t;

	typedef enum logic [2:0] {
		REG_COEF_UU   = 3'd0,
		REG_COEF_UV   = 3'd1,
		REG_COEF_VU   = 3'd2,
		REG_COEF_VV   = 3'd3,
		REG_OFFSET_U  = 3'd4,
		REG_OFFSET_V  = 3'd5,
		REG_WRAP_MODE = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] coef_uu;
		logic signed [31:0] coef_uv;
		logic signed [31:0] coef_vu;
		logic signed [31:0] coef_vv;
		logic signed [31:0] offset_u;
		logic signed [31:0] offset_v;
	} xform_cfg_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] tu;
		logic signed [31:0] tv;
		logic signed [31:0] u0;
		logic signed [31:0] v0;
	} xform_beat_t;

endpackage

>>> sv/tct_xform.sv
// Centering, 2x2 matrix multiply, offset add and saturation (stages one to three).
`include "texture_coord_transform_wrap_core_macros.svh"

module tct_xform #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [31:0]  u_in,
	input  logic signed [31:0]  v_in,
	input  tct_pkg::xform_cfg_t cfg,
	output tct_pkg::xform_beat_t beat
);

	localparam int PW = 65;
	localparam int SW = PW - FRAC_BITS;
	localparam int SUMW = SW + 2;
	localparam logic signed [32:0] HALF = 33'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [31:0] S32MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32MIN = 32'sh80000000;

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [31:0] u0_s1, v0_s1, u0_s2, v0_s2, u0_s3, v0_s3;
	logic signed [32:0] uc_s1, vc_s1;
	logic signed [32:0] uc_d, vc_d;
	logic signed [PW-1:0] p_uu_s2, p_uv_s2, p_vu_s2, p_vv_s2;
	logic signed [SW-1:0] f_uu, f_uv, f_vu, f_vv;
	logic signed [SUMW-1:0] sum_u, sum_v;
	logic signed [31:0] tu_s3, tv_s3;

	function automatic logic signed [31:0] sat32(input logic signed [SUMW-1:0] x);
		logic ovf;
		logic signed [31:0] r;
		ovf = (x[SUMW-1:31] != {(SUMW - 31){x[SUMW-1]}});
		if (!ovf) begin
			r = x[31:0];
		end else if (x[SUMW-1]) begin
			r = S32MIN;
		end else begin
			r = S32MAX;
		end
		return r;
	endfunction

	assign uc_d = 33'(u_in) - HALF;
	assign vc_d = 33'(v_in) - HALF;

	// Arithmetic right shift rounds each product toward minus infinity.
	assign f_uu = p_uu_s2[PW-1:FRAC_BITS];
	assign f_uv = p_uv_s2[PW-1:FRAC_BITS];
	assign f_vu = p_vu_s2[PW-1:FRAC_BITS];
	assign f_vv = p_vv_s2[PW-1:FRAC_BITS];
	assign sum_u = SUMW'(f_uu) + SUMW'(f_uv) + SUMW'(cfg.offset_u);
	assign sum_v = SUMW'(f_vu) + SUMW'(f_vv) + SUMW'(cfg.offset_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		u0_s1   <= u_in;
		v0_s1   <= v_in;
		uc_s1   <= uc_d;
		vc_s1   <= vc_d;
		u0_s2   <= u0_s1;
		v0_s2   <= v0_s1;
		p_uu_s2 <= PW'(cfg.coef_uu) * PW'(uc_s1);
		p_uv_s2 <= PW'(cfg.coef_uv) * PW'(vc_s1);
		p_vu_s2 <= PW'(cfg.coef_vu) * PW'(uc_s1);
		p_vv_s2 <= PW'(cfg.coef_vv) * PW'(vc_s1);
		u0_s3   <= u0_s2;
		v0_s3   <= v0_s2;
		tu_s3   <= sat32(sum_u);
		tv_s3   <= sat32(sum_v);
	end

	assign beat.valid = valid_s3;
	assign beat.tu    = tu_s3;
	assign beat.tv    = tv_s3;
	assign beat.u0    = u0_s3;
	assign beat.v0    = v0_s3;

	`TCT_ASSERT_NOW(a_xf_latency, valid_s3, $past(in_valid, 3))
	`TCT_ASSERT_NEXT(a_xf_sat_hi, valid_s2 && (sum_u > SUMW'(S32MAX)), tu_s3 == S32MAX)
	`TCT_ASSERT_NEXT(a_xf_zero_coef, valid_s1 && (cfg.coef_uu == '0), p_uu_s2 == '0)

endmodule

>>> sv/tct_wrap.sv
// Wrap stage: repeat, mirror, clamp, planar and cubic face mapping (stages four to seven).
`include "texture_coord_transform_wrap_core_macros.svh"

module tct_wrap #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tct_pkg::xform_beat_t beat,
	input  logic [2:0]           mode,
	output logic                 done,
	output logic signed [31:0]   u_out,
	output logic signed [31:0]   v_out
);

	localparam int LW = FRAC_BITS + 2;
	localparam int QW = 34 - FRAC_BITS;
	localparam int FW = 36 - FRAC_BITS;
	localparam int NCH = (FW + 1) / 2;
	localparam int CSW = $clog2(3 * NCH + 1);
	localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [LW-1:0] ONE_L = LW'(ONE32);
	localparam logic [FRAC_BITS:0] ONE_M = ONE32[FRAC_BITS:0];

	logic                   valid_s4, valid_s5, valid_s6, valid_s7;
	logic signed [33:0]     us_s4, vs_s4, us_d, vs_d;
	logic signed [31:0]     tu_s4, tv_s4, tu_s5, tv_s5, tu_s6, tv_s6;
	logic signed [31:0]     alt_u_s4, alt_v_s4, alt_u_s5, alt_v_s5, alt_u_s6, alt_v_s6;
	logic                   cubic_s4, cubic_s5, cubic_s6;
	logic signed [QW-1:0]   qf_u, qf_v;
	logic                   cor_u, cor_v;
	logic [2:0]             cor_sum;
	logic [FRAC_BITS-1:0]   low_u, low_v;
	logic signed [LW-1:0]   lu_d, lv_d, lu_s5, lv_s5, lu_s6, lv_s6;
	logic signed [FW-1:0]   face_d, face_s5;
	logic [FW-1:0]          mag;
	logic [2*NCH-1:0]       mag_p;
	logic [CSW-1:0]         csum_d, csum_s6;
	logic                   par_s6, neg_s6;
	logic [5:0]             c6;
	logic [3:0]             fold;
	logic [1:0]             m3;
	logic [2:0]             m6;
	logic                   neg_rem;
	logic signed [LW-1:0]   cb_u, cb_v;
	logic signed [31:0]     res_u, res_v, u_s7, v_s7;

	function automatic logic signed [31:0] alt_coord(input logic [2:0] m,
			input logic signed [31:0] t, input logic signed [31:0] o);
		logic [FRAC_BITS:0] mr;
		logic signed [31:0] r;
		mr = t[FRAC_BITS:0];
		r = t;
		unique case (m)
			tct_pkg::WRAP_REPEAT: r = 32'(t[FRAC_BITS-1:0]);
			tct_pkg::WRAP_MIRROR: begin
				if (mr > ONE_M) begin
					r = (ONE32 <<< 1) - 32'(mr);
				end else begin
					r = 32'(mr);
				end
			end
			tct_pkg::WRAP_CLAMP: begin
				if (t < 0) begin
					r = '0;
				end else if (t > ONE32) begin
					r = ONE32;
				end else begin
					r = t;
				end
			end
			tct_pkg::WRAP_PLANAR: r = o;
			default: r = t;
		endcase
		return r;
	endfunction

	// Stage four: scale by three for the cube face grid.
	assign us_d = 34'(beat.tu) + (34'(beat.tu) <<< 1);
	assign vs_d = 34'(beat.tv) + (34'(beat.tv) <<< 1);

	// Stage five: truncating quotient and remainder by ONE, then the face number.
	assign qf_u  = us_s4[33:FRAC_BITS];
	assign qf_v  = vs_s4[33:FRAC_BITS];
	assign low_u = us_s4[FRAC_BITS-1:0];
	assign low_v = vs_s4[FRAC_BITS-1:0];
	assign cor_u = us_s4[33] && (low_u != '0);
	assign cor_v = vs_s4[33] && (low_v != '0);
	assign lu_d  = cor_u ? (LW'(low_u) - ONE_L) : LW'(low_u);
	assign lv_d  = cor_v ? (LW'(low_v) - ONE_L) : LW'(low_v);
	assign cor_sum = {1'b0, cor_v, cor_v} + {2'b00, cor_u};
	assign face_d = FW'(qf_u) + FW'(qf_v) + (FW'(qf_v) <<< 1) + FW'(cor_sum);

	// Stage six: magnitude of the face number and its base-four digit sum.
	assign mag   = face_s5[FW-1] ? FW'(-face_s5) : FW'(face_s5);
	assign mag_p = (2 * NCH)'(mag);

	always_comb begin
		csum_d = '0;
		for (int i = 0; i < NCH; i++) begin
			csum_d = csum_d + CSW'(mag_p[2*i +: 2]);
		end
	end

	// Stage seven: remainder modulo six from the residues modulo three and two.
	assign c6   = 6'(csum_s6);
	assign fold = 4'(c6[1:0]) + 4'(c6[3:2]) + 4'(c6[5:4]);

	always_comb begin
		if (fold >= 4'd6) begin
			m3 = 2'(fold - 4'd6);
		end else if (fold >= 4'd3) begin
			m3 = 2'(fold - 4'd3);
		end else begin
			m3 = fold[1:0];
		end
	end

	assign m6      = (m3[0] == par_s6) ? {1'b0, m3} : ({1'b0, m3} + 3'd3);
	assign neg_rem = neg_s6 && (m6 != 3'd0);

	always_comb begin
		unique case (m6)
			3'd1: begin
				cb_u = lv_s6;
				cb_v = ONE_L - lu_s6;
			end
			3'd2: begin
				cb_u = ONE_L - lu_s6;
				cb_v = lv_s6;
			end
			3'd3: begin
				cb_u = ONE_L - lv_s6;
				cb_v = ONE_L - lu_s6;
			end
			3'd4: begin
				cb_u = lu_s6;
				cb_v = ONE_L - lv_s6;
			end
			default: begin
				cb_u = lu_s6;
				cb_v = lv_s6;
			end
		endcase
	end

	always_comb begin
		if (!cubic_s6) begin
			res_u = alt_u_s6;
			res_v = alt_v_s6;
		end else if (neg_rem) begin
			res_u = tu_s6;
			res_v = tv_s6;
		end else begin
			res_u = 32'(cb_u);
			res_v = 32'(cb_v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s4 <= beat.valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		us_s4    <= us_d;
		vs_s4    <= vs_d;
		tu_s4    <= beat.tu;
		tv_s4    <= beat.tv;
		alt_u_s4 <= alt_coord(mode, beat.tu, beat.u0);
		alt_v_s4 <= alt_coord(mode, beat.tv, beat.v0);
		cubic_s4 <= (mode == tct_pkg::WRAP_CUBIC);

		face_s5  <= face_d;
		lu_s5    <= lu_d;
		lv_s5    <= lv_d;
		tu_s5    <= tu_s4;
		tv_s5    <= tv_s4;
		alt_u_s5 <= alt_u_s4;
		alt_v_s5 <= alt_v_s4;
		cubic_s5 <= cubic_s4;

		csum_s6  <= csum_d;
		par_s6   <= mag[0];
		neg_s6   <= face_s5[FW-1];
		lu_s6    <= lu_s5;
		lv_s6    <= lv_s5;
		tu_s6    <= tu_s5;
		tv_s6    <= tv_s5;
		alt_u_s6 <= alt_u_s5;
		alt_v_s6 <= alt_v_s5;
		cubic_s6 <= cubic_s5;

		u_s7     <= res_u;
		v_s7     <= res_v;
	end

	assign done  = valid_s7;
	assign u_out = u_s7;
	assign v_out = v_s7;

	`TCT_ASSERT_NOW(a_wr_latency, valid_s7, $past(beat.valid, 4))
	`TCT_ASSERT_NOW(a_wr_m6_range, valid_s6, m6 <= 3'd5)
	`TCT_ASSERT_NEXT(a_wr_rem_sign, valid_s4 && !us_s4[33], !lu_s5[LW-1])

endmodule

>>> sv/texture_coord_transform_wrap_core.sv
// Top level of the texture coordinate transform with wrap modes.
//
//  channel   handshake       payload                  direction
//  input     start / busy    u_in, v_in               in
//  result    done            u_out, v_out             out
//  config    cfg_we          cfg_idx, cfg_wdata       in
//
// One beat is taken in every cycle; busy is held low.
// A result appears on done once its beat has passed through the registered transform and wrap stages.
// The depth is set by the four 32x33 multipliers of stage two and the cube face steps.
// Reset clears all valid bits and loads the default matrix, offsets and repeat mode.
// The receiver cannot stall, so no beat is ever held back.
module texture_coord_transform_wrap_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] u_in,
	input  logic signed [31:0] v_in,
	output logic               done,
	output logic signed [31:0] u_out,
	output logic signed [31:0] v_out,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata
);

	localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] HALF32 = 32'sd1 <<< (FRAC_BITS - 1);

	tct_pkg::xform_cfg_t  cfg_q;
	logic [2:0]           wrap_mode_q;
	tct_pkg::xform_beat_t beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_uu  <= ONE32;
			cfg_q.coef_uv  <= '0;
			cfg_q.coef_vu  <= '0;
			cfg_q.coef_vv  <= ONE32;
			cfg_q.offset_u <= HALF32;
			cfg_q.offset_v <= HALF32;
			wrap_mode_q    <= tct_pkg::WRAP_REPEAT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tct_pkg::REG_COEF_UU:   cfg_q.coef_uu  <= cfg_wdata;
				tct_pkg::REG_COEF_UV:   cfg_q.coef_uv  <= cfg_wdata;
				tct_pkg::REG_COEF_VU:   cfg_q.coef_vu  <= cfg_wdata;
				tct_pkg::REG_COEF_VV:   cfg_q.coef_vv  <= cfg_wdata;
				tct_pkg::REG_OFFSET_U:  cfg_q.offset_u <= cfg_wdata;
				tct_pkg::REG_OFFSET_V:  cfg_q.offset_v <= cfg_wdata;
				tct_pkg::REG_WRAP_MODE: wrap_mode_q    <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	tct_xform #(
		.FRAC_BITS(FRAC_BITS)
	) u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(start && !busy),
		.u_in    (u_in),
		.v_in    (v_in),
		.cfg     (cfg_q),
		.beat    (beat)
	);

	tct_wrap #(
		.FRAC_BITS(FRAC_BITS)
	) u_wrap (
		.clk   (clk),
		.arst_n(arst_n),
		.beat  (beat),
		.mode  (wrap_mode_q),
		.done  (done),
		.u_out (u_out),
		.v_out (v_out)
	);

endmodule

>>> tb/tb_texture_coord_transform_wrap_core.sv
// Self-checking testbench for the texture coordinate transform and wrap core.
module tb_texture_coord_transform_wrap_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam longint ONE = longint'(1) << FRAC;
	localparam longint HALF = longint'(1) << (FRAC - 1);
	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;
	localparam int PIPE_LAT = 7;
	localparam int STALL_LIMIT = 4000;
	localparam logic [31:0] FX_ONE = 32'h0001_0000;
	localparam logic [31:0] FX_HALF = 32'h0000_8000;
	localparam logic [31:0] FX_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] FX_MIN = 32'h8000_0000;
	localparam logic [2:0] WRAP_RSVD5 = 3'd5;
	localparam logic [2:0] WRAP_RSVD6 = 3'd6;
	localparam logic [2:0] WRAP_RSVD7 = 3'd7;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [31:0] u;
		logic [31:0] v;
	} coord_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] u_in = '0;
	logic signed [31:0] v_in = '0;
	logic done;
	logic signed [31:0] u_out;
	logic signed [31:0] v_out;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;

	// Local copy of the transform registers, at their reset values.
	logic signed [31:0] mat_uu = FX_ONE;
	logic signed [31:0] mat_uv = '0;
	logic signed [31:0] mat_vu = '0;
	logic signed [31:0] mat_vv = FX_ONE;
	logic signed [31:0] shift_u = FX_HALF;
	logic signed [31:0] shift_v = FX_HALF;
	logic [2:0] wrap_sel = tct_pkg::WRAP_REPEAT;

	coord_pair_t pending_coords[$];
	int sender_idle_pct = 15;
	int n_errors = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_settings = 0;
	int stall_cycles = 0;

	texture_coord_transform_wrap_core #(.FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.u_in(u_in),
		.v_in(v_in),
		.done(done),
		.u_out(u_out),
		.v_out(v_out),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint clip32(input longint x);
		if (x > S32_HI)
			return S32_HI;
		if (x < S32_LO)
			return S32_LO;
		return x;
	endfunction

	function automatic void predict_wrap(input logic signed [31:0] u0, input logic signed [31:0] v0,
			output logic [31:0] ru, output logic [31:0] rv);
		longint uc, vc, tu, tv, wu, wv, us, vs, face, lu, lv;
		uc = longint'(u0) - HALF;
		vc = longint'(v0) - HALF;
		tu = clip32(((longint'(mat_uu) * uc) >>> FRAC) + ((longint'(mat_uv) * vc) >>> FRAC)
			+ longint'(shift_u));
		tv = clip32(((longint'(mat_vu) * uc) >>> FRAC) + ((longint'(mat_vv) * vc) >>> FRAC)
			+ longint'(shift_v));
		wu = tu;
		wv = tv;
		case (wrap_sel)
			tct_pkg::WRAP_REPEAT: begin
				wu = tu & (ONE - 1);
				wv = tv & (ONE - 1);
			end
			tct_pkg::WRAP_MIRROR: begin
				wu = tu & (2 * ONE - 1);
				wv = tv & (2 * ONE - 1);
				if (wu > ONE)
					wu = 2 * ONE - wu;
				if (wv > ONE)
					wv = 2 * ONE - wv;
			end
			tct_pkg::WRAP_CLAMP: begin
				wu = (tu < 0) ? 0 : ((tu > ONE) ? ONE : tu);
				wv = (tv < 0) ? 0 : ((tv > ONE) ? ONE : tv);
			end
			tct_pkg::WRAP_PLANAR: begin
				wu = longint'(u0);
				wv = longint'(v0);
			end
			tct_pkg::WRAP_CUBIC: begin
				us = tu * 3;
				vs = tv * 3;
				face = us / ONE + 3 * (vs / ONE);
				lu = us % ONE;
				lv = vs % ONE;
				case (face % 6)
					0, 5: begin
						wu = lu;
						wv = lv;
					end
					1: begin
						wu = lv;
						wv = ONE - lu;
					end
					2: begin
						wu = ONE - lu;
						wv = lv;
					end
					3: begin
						wu = ONE - lv;
						wv = ONE - lu;
					end
					4: begin
						wu = lu;
						wv = ONE - lv;
					end
					default: begin
						wu = tu;
						wv = tv;
					end
				endcase
			end
			default: begin
				wu = tu;
				wv = tv;
			end
		endcase
		ru = 32'(wu);
		rv = 32'(wv);
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(11))
			0: return FX_MAX;
			1: return FX_MIN;
			2: return $urandom;
			default: return 32'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(15))
			0: return FX_MAX;
			1: return FX_MIN;
			2, 3: return $urandom;
			default: return 32'(int'($urandom_range(0, 6 * 65536)) - 3 * 65536);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		n_errors++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			tct_pkg::REG_COEF_UU: mat_uu = val;
			tct_pkg::REG_COEF_UV: mat_uv = val;
			tct_pkg::REG_COEF_VU: mat_vu = val;
			tct_pkg::REG_COEF_VV: mat_vv = val;
			tct_pkg::REG_OFFSET_U: shift_u = val;
			tct_pkg::REG_OFFSET_V: shift_v = val;
			tct_pkg::REG_WRAP_MODE: wrap_sel = val[2:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [31:0] uu, input logic [31:0] uv,
			input logic [31:0] vu, input logic [31:0] vv, input logic [31:0] ou,
			input logic [31:0] ov, input logic [31:0] mode_word);
		write_reg(tct_pkg::REG_COEF_UU, uu);
		write_reg(tct_pkg::REG_COEF_UV, uv);
		write_reg(tct_pkg::REG_COEF_VU, vu);
		write_reg(tct_pkg::REG_COEF_VV, vv);
		write_reg(tct_pkg::REG_OFFSET_U, ou);
		write_reg(tct_pkg::REG_OFFSET_V, ov);
		write_reg(tct_pkg::REG_WRAP_MODE, mode_word);
		cfg_we <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	task automatic send_coord(input logic [31:0] u, input logic [31:0] v);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		u_in <= u;
		v_in <= v;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic settle_pipeline();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_coords.size() != 0);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_coord(32'h0, 32'h0);
		send_coord(FX_ONE, FX_ONE);
		send_coord(FX_MAX, FX_MIN);
		send_coord(FX_MIN, FX_MAX);
		send_coord(32'h0000_7FFF, 32'hFFFF_FFFF);
		settle_pipeline();
	endtask

	task automatic test_saturation();
		apply_settings(FX_MAX, FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MIN,
			{29'd0, tct_pkg::WRAP_CLAMP});
		send_coord(FX_MAX, FX_MAX);
		send_coord(FX_MIN, FX_MIN);
		send_coord(FX_MIN, FX_MAX);
		settle_pipeline();
	endtask

	task automatic test_each_wrap_code();
		logic [2:0] codes[8];
		codes = '{tct_pkg::WRAP_REPEAT, tct_pkg::WRAP_MIRROR, tct_pkg::WRAP_CLAMP,
			tct_pkg::WRAP_PLANAR, tct_pkg::WRAP_CUBIC, WRAP_RSVD5, WRAP_RSVD6, WRAP_RSVD7};
		foreach (codes[i]) begin
			apply_settings(FX_ONE, 32'h0, 32'h0, FX_ONE, FX_HALF, FX_HALF, {29'd0, codes[i]});
			send_coord(32'h0000_C000, 32'h0000_2000);
			// In cubic mode this beat lands on a negative face.
			send_coord(32'hFFFE_4000, 32'hFFFF_6000);
			settle_pipeline();
		end
	endtask

	task automatic test_unused_index();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		cfg_we <= 1'b0;
		@(posedge clk);
		send_coord(32'h0001_4000, 32'hFFFF_C000);
		settle_pipeline();
	endtask

	task automatic test_random_traffic(input int idle_pct);
		logic [31:0] mode_word;
		sender_idle_pct = idle_pct;
		repeat (8) begin
			mode_word = $urandom;
			mode_word[2:0] = ($urandom_range(9) > 7) ? tct_pkg::WRAP_CUBIC
				: 3'($urandom_range(7));
			apply_settings(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
				rand_coef(), mode_word);
			repeat (29) send_coord(rand_coord(), rand_coord());
			settle_pipeline();
		end
	endtask

	always @(posedge clk) begin
		coord_pair_t want, got;
		if (arst_n) begin
			if (done) begin
				n_checked++;
				if (pending_coords.size() == 0) begin
					report_mismatch($sformatf("result %h %h with nothing pending", u_out, v_out));
				end else begin
					want = pending_coords.pop_front();
					if (u_out !== want.u)
						report_mismatch($sformatf("u_out %h, expected %h", u_out, want.u));
					if (v_out !== want.v)
						report_mismatch($sformatf("v_out %h, expected %h", v_out, want.v));
				end
			end
			if (start && !busy) begin
				predict_wrap(u_in, v_in, got.u, got.v);
				pending_coords.push_back(got);
				n_accepted++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Watchdog expired with %0d results pending.", pending_coords.size());
				$display("texture_coord_transform_wrap_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_saturation();
		test_each_wrap_code();
		test_unused_index();
		test_random_traffic(15);
		test_random_traffic(81);
		test_random_traffic(0);
		settle_pipeline();
		$display("Sent %0d coordinate beats and checked %0d results over %0d register settings.",
			n_accepted, n_checked, n_settings);
		$display("All eight wrap codes, saturating sums and sender gaps of 15, 81 and 0 percent.");
		if (n_errors == 0 && pending_coords.size() == 0)
			$display("texture_coord_transform_wrap_core regression: pass");
		else
			$display("texture_coord_transform_wrap_core regression: fail");
		$finish;
	end

endmodule

>>> texture_coord_transform_wrap_core.f
+incdir+sv
sv/tct_pkg.sv
sv/tct_xform.sv
sv/tct_wrap.sv
sv/texture_coord_transform_wrap_core.sv
tb/tb_texture_coord_transform_wrap_core.sv
